// ----- rtl/ppci_pkg.sv -----
// shared constants, types and a function for the planar pose compose and invert block
package ppci_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int ANGLE_WIDTH    = 16;
    localparam int PHASE_WIDTH    = 32;
    localparam int CORDIC_STEPS   = 30;
    localparam int CORDIC_W       = 34;
    localparam int ZW             = 33;
    localparam int PRODUCT_W      = POSITION_WIDTH + CORDIC_W;
    localparam int SUM_W          = PRODUCT_W + 1;
    localparam int ROUND_W        = SUM_W - 30 + 1;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    typedef enum logic {
        FUNC_COMPOSE = 1'b0,
        FUNC_INVERT  = 1'b1
    } t_func;

    // payload carried alongside the sine-cosine path
    typedef struct packed {
        logic                             invert;
        logic signed [POSITION_WIDTH-1:0] bx;
        logic signed [POSITION_WIDTH-1:0] by;
        logic signed [POSITION_WIDTH-1:0] ox;
        logic signed [POSITION_WIDTH-1:0] oy;
        logic        [ANGLE_WIDTH-1:0]    heading;
    } t_pose;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ZW-1:0]       z;
        logic                       flip;
    } t_cordic;

    function automatic logic [PHASE_WIDTH-1:0] atan_phase(input int i);
        logic [PHASE_WIDTH-1:0] r;
        begin
            case (i)
                0:  r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
                3:  r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
                6:  r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
                9:  r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
                12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
                15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
                18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
                21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
                24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
                27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/ppci_cordic_stage.sv -----
// one registered rotation step of the sine-cosine pipeline
module ppci_cordic_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_step,
    input  logic                i_valid,
    input  ppci_pkg::t_cordic   i_c,
    input  ppci_pkg::t_pose     i_p,
    output logic                o_valid,
    output ppci_pkg::t_cordic   o_c,
    output ppci_pkg::t_pose     o_p
);
    ppci_pkg::t_cordic n_c;
    ppci_pkg::t_cordic r_c;
    ppci_pkg::t_pose   r_p;
    logic              r_valid;
    logic signed [ppci_pkg::ZW-1:0] atn;

    always_comb begin
        atn = ppci_pkg::ZW'(ppci_pkg::atan_phase(int'(i_step)));
        n_c = i_c;
        if (!i_c.z[ppci_pkg::ZW-1]) begin
            n_c.x = i_c.x - (i_c.y >>> i_step);
            n_c.y = i_c.y + (i_c.x >>> i_step);
            n_c.z = i_c.z - atn;
        end else begin
            n_c.x = i_c.x + (i_c.y >>> i_step);
            n_c.y = i_c.y - (i_c.x >>> i_step);
            n_c.z = i_c.z + atn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_c <= n_c;
        r_p <= i_p;
    end

    assign o_valid = r_valid;
    assign o_c     = r_c;
    assign o_p     = r_p;
endmodule

// ----- rtl/ppci_sincos.sv -----
// pipelined sine-cosine generator with pose payload riding along
module ppci_sincos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  ppci_pkg::t_pose                   i_p,
    output logic                              o_valid,
    output ppci_pkg::t_pose                   o_p,
    output logic signed [ppci_pkg::CORDIC_W-1:0] o_sin,
    output logic signed [ppci_pkg::CORDIC_W-1:0] o_cos
);
    localparam int N = ppci_pkg::CORDIC_STEPS;
    logic              v [N+1];
    ppci_pkg::t_cordic c [N+1];
    ppci_pkg::t_pose   p [N+1];
    logic [ppci_pkg::PHASE_WIDTH-1:0] ph;
    logic [ppci_pkg::PHASE_WIDTH-1:0] phf;
    logic                             flip;

    always_comb begin
        ph   = {i_p.heading, {(ppci_pkg::PHASE_WIDTH-ppci_pkg::ANGLE_WIDTH){1'b0}}};
        flip = ph[31] ^ ph[30];
        phf  = flip ? ph - 32'h80000000 : ph;
    end

    assign c[0] = {ppci_pkg::CORDIC_GAIN, ppci_pkg::CORDIC_W'(0),
                   ppci_pkg::ZW'(signed'(phf)), flip};
    assign v[0] = i_valid;
    assign p[0] = i_p;

    for (genvar g = 0; g < N; g++) begin : g_stage
        ppci_cordic_stage u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(5'(g)),
            .i_valid(v[g]), .i_c(c[g]), .i_p(p[g]),
            .o_valid(v[g+1]), .o_c(c[g+1]), .o_p(p[g+1])
        );
    end

    assign o_valid = v[N];
    assign o_p     = p[N];
    assign o_cos   = c[N].flip ? -c[N].x : c[N].x;
    assign o_sin   = c[N].flip ? -c[N].y : c[N].y;
endmodule

// ----- rtl/ppci_rotate.sv -----
// rotation products, rounding, offset add and saturation in three stages
module ppci_rotate (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  ppci_pkg::t_pose                      i_p,
    input  logic signed [ppci_pkg::CORDIC_W-1:0] i_sin,
    input  logic signed [ppci_pkg::CORDIC_W-1:0] i_cos,
    output logic                                 o_valid,
    output logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_x,
    output logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_y,
    output logic        [ppci_pkg::ANGLE_WIDTH-1:0]    o_heading,
    output logic                                 o_sat
);
    localparam int PW = ppci_pkg::POSITION_WIDTH;
    localparam int CW = ppci_pkg::CORDIC_W;
    localparam int MW = ppci_pkg::PRODUCT_W;
    localparam int SW = ppci_pkg::SUM_W;
    localparam int RW = ppci_pkg::ROUND_W;
    localparam int AW = ppci_pkg::ANGLE_WIDTH;

    logic signed [PW-1:0] p, q, offx, offy;
    logic signed [CW-1:0] a0, b0, a1, b1;
    logic [AW-1:0]        hd;

    always_comb begin
        if (i_p.invert == ppci_pkg::FUNC_INVERT) begin
            p = i_p.bx; q = i_p.by; offx = '0; offy = '0;
            a0 = -i_cos; b0 = -i_sin; a1 = i_sin; b1 = -i_cos;
            hd = AW'(0) - i_p.heading;
        end else begin
            p = i_p.ox; q = i_p.oy; offx = i_p.bx; offy = i_p.by;
            a0 = i_cos; b0 = -i_sin; a1 = i_sin; b1 = i_cos;
            hd = i_p.heading;
        end
    end

    // stage 1: products
    logic signed [MW-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [PW-1:0] r1_ox, r1_oy;
    logic [AW-1:0]        r1_h;
    logic                 r1_v;
    // stage 2: sums rounded
    logic signed [RW-1:0] r_rx, r_ry;
    logic signed [PW-1:0] r2_ox, r2_oy;
    logic [AW-1:0]        r2_h;
    logic                 r2_v;
    // stage 3: offset and clamp
    logic signed [PW-1:0] r_x, r_y;
    logic [AW-1:0]        r3_h;
    logic                 r_sat, r3_v;

    logic signed [SW-1:0] sx, sy;
    logic signed [RW:0]   n_tx, n_ty;
    logic signed [PW-1:0] n_x, n_y;
    logic                 n_sat;
    logic signed [RW:0]   hi_l, lo_l;

    always_comb begin
        sx = SW'(r_m0) + SW'(r_m1) + SW'(64'sd1 <<< 29);
        sy = SW'(r_m2) + SW'(r_m3) + SW'(64'sd1 <<< 29);
        n_tx = (RW+1)'(r_rx) + (RW+1)'(r2_ox);
        n_ty = (RW+1)'(r_ry) + (RW+1)'(r2_oy);
        hi_l = (RW+1)'({1'b0, {(PW-1){1'b1}}});
        lo_l = -hi_l - 1;
        n_sat = 1'b0;
        if (n_tx > hi_l) begin
            n_x = PW'(hi_l); n_sat = 1'b1;
        end else if (n_tx < lo_l) begin
            n_x = PW'(lo_l); n_sat = 1'b1;
        end else begin
            n_x = PW'(n_tx);
        end
        if (n_ty > hi_l) begin
            n_y = PW'(hi_l); n_sat = 1'b1;
        end else if (n_ty < lo_l) begin
            n_y = PW'(lo_l); n_sat = 1'b1;
        end else begin
            n_y = PW'(n_ty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v;
        end
        r_m0 <= MW'(p) * MW'(a0);
        r_m1 <= MW'(q) * MW'(b0);
        r_m2 <= MW'(p) * MW'(a1);
        r_m3 <= MW'(q) * MW'(b1);
        r1_ox <= offx; r1_oy <= offy; r1_h <= hd;
        r_rx <= RW'(sx >>> 30);
        r_ry <= RW'(sy >>> 30);
        r2_ox <= r1_ox; r2_oy <= r1_oy; r2_h <= r1_h;
        r_x <= n_x; r_y <= n_y; r_sat <= n_sat; r3_h <= r2_h;
    end

    assign o_valid   = r3_v;
    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_heading = r3_h;
    assign o_sat     = r_sat;
endmodule

// ----- rtl/planar_pose_compose_invert.sv -----
// top level of the planar pose compose and invert pipeline
//
// channels: a command word is taken on start while busy is low; busy is
// always low, so a word may enter every cycle. each word gives one result word
// on o_out_x, o_out_y, o_out_heading and o_saturated, marked by o_done for one
// cycle.
// pipeline: 30 sine-cosine rotation stages, then products, rounding and
// offset-with-clamp stages. throughput: one word per cycle, set by the fully
// pipelined rotation and multiply path.
// reset: i_rst_n low for one edge drops every word in flight; no result
// follows for words accepted before reset.
// the receiver cannot stall; results are shown once and never held.
// func 0 composes the base pose with the other pose, func 1 inverts the base
// pose and ignores the other pose.
module planar_pose_compose_invert (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic                                       i_func,
    input  logic signed [ppci_pkg::POSITION_WIDTH-1:0] i_base_x,
    input  logic signed [ppci_pkg::POSITION_WIDTH-1:0] i_base_y,
    input  logic signed [ppci_pkg::ANGLE_WIDTH-1:0]    i_base_heading,
    input  logic signed [ppci_pkg::POSITION_WIDTH-1:0] i_other_x,
    input  logic signed [ppci_pkg::POSITION_WIDTH-1:0] i_other_y,
    input  logic signed [ppci_pkg::ANGLE_WIDTH-1:0]    i_other_heading,
    output logic                                       o_done,
    output logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_out_x,
    output logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_out_y,
    output logic signed [ppci_pkg::ANGLE_WIDTH-1:0]    o_out_heading,
    output logic                                       o_saturated
);
    ppci_pkg::t_pose in_p, sc_p;
    logic            sc_v;
    logic signed [ppci_pkg::CORDIC_W-1:0] s_sin, s_cos;
    logic [ppci_pkg::ANGLE_WIDTH-1:0]     hd;

    assign busy = 1'b0;

    always_comb begin
        in_p.invert = i_func;
        in_p.bx = i_base_x;
        in_p.by = i_base_y;
        in_p.ox = i_other_x;
        in_p.oy = i_other_y;
        in_p.heading = i_base_heading;
    end

    // heading sum done late from the rotated base heading is not possible, so
    // carry both: compose sum is formed here and delayed beside the pipeline
    ppci_pkg::t_pose in_q;
    always_comb begin
        in_q = in_p;
    end

    logic [ppci_pkg::ANGLE_WIDTH-1:0] r_hsum [33];
    always_ff @(posedge i_clk) begin
        r_hsum[0] <= i_base_heading + i_other_heading;
        for (int k = 1; k < 33; k++) begin
            r_hsum[k] <= r_hsum[k-1];
        end
    end

    ppci_sincos u_sincos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy), .i_p(in_q),
        .o_valid(sc_v), .o_p(sc_p), .o_sin(s_sin), .o_cos(s_cos)
    );

    ppci_rotate u_rotate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(sc_v), .i_p(sc_p),
        .i_sin(s_sin), .i_cos(s_cos), .o_valid(o_done),
        .o_x(o_out_x), .o_y(o_out_y), .o_heading(hd), .o_sat(o_saturated)
    );

    logic r_inv [33];
    always_ff @(posedge i_clk) begin
        r_inv[0] <= i_func;
        for (int k = 1; k < 33; k++) begin
            r_inv[k] <= r_inv[k-1];
        end
    end

    assign o_out_heading = (r_inv[32] == ppci_pkg::FUNC_INVERT) ? hd : r_hsum[32];
endmodule

// ----- rtl/ppci_checker.sv -----
// port-level checks for the planar pose compose and invert block
module ppci_checker (
    input logic                                       i_clk,
    input logic                                       i_rst_n,
    input logic                                       start,
    input logic                                       busy,
    input logic                                       o_done,
    input logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_out_x,
    input logic signed [ppci_pkg::POSITION_WIDTH-1:0] o_out_y,
    input logic                                       o_saturated
);
    localparam logic signed [ppci_pkg::POSITION_WIDTH-1:0] PMAX =
        {1'b0, {(ppci_pkg::POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [ppci_pkg::POSITION_WIDTH-1:0] PMIN =
        {1'b1, {(ppci_pkg::POSITION_WIDTH-1){1'b0}}};

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_idle_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("done right after reset");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##33 o_done)
        else $error("accepted word without a result");
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
        (o_out_x == PMAX || o_out_x == PMIN || o_out_y == PMAX || o_out_y == PMIN))
        else $error("saturated flag without a clamped position");
endmodule

bind planar_pose_compose_invert ppci_checker u_ppci_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_out_x(o_out_x), .o_out_y(o_out_y),
    .o_saturated(o_saturated)
);

// ----- dv/testbench.sv -----
// testbench for planar_pose_compose_invert: queued driver, pose predictor, result monitor
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        ppci_pkg::t_func           func;
        logic signed [31:0]        bx, by, ox, oy;
        logic signed [15:0]        bh, oh;
    } t_cmd;

    typedef struct {
        logic signed [31:0] x, y;
        logic signed [15:0] heading;
        logic               sat;
    } t_pose_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_func = 1'b0;
    logic signed [31:0] i_base_x = '0, i_base_y = '0, i_other_x = '0, i_other_y = '0;
    logic signed [15:0] i_base_heading = '0, i_other_heading = '0;
    logic o_done, o_saturated;
    logic signed [31:0] o_out_x, o_out_y;
    logic signed [15:0] o_out_heading;

    t_cmd      pending_words[$];
    t_pose_out expected_poses[$];
    int        errors = 0;
    int        calm_tail = 0;
    int        gap_left = 0;
    longint    cycles = 0;
    bit        stim_done = 0;

    planar_pose_compose_invert DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_base_x(i_base_x), .i_base_y(i_base_y),
        .i_base_heading(i_base_heading), .i_other_x(i_other_x), .i_other_y(i_other_y),
        .i_other_heading(i_other_heading), .o_done(o_done), .o_out_x(o_out_x),
        .o_out_y(o_out_y), .o_out_heading(o_out_heading), .o_saturated(o_saturated)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic heading_sin_cos(input logic [15:0] h, output longint s, output longint c);
        logic [31:0] ph;
        longint x, y, z, dx, dy;
        bit flip;
        ph = {h, 16'h0};
        flip = 0;
        x = 652032874;
        y = 0;
        if (ph >= 32'h40000000 && ph < 32'hC0000000) begin
            ph = ph - 32'h80000000;
            flip = 1;
        end
        z = longint'($signed(ph));
        for (int i = 0; i < ppci_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_phase_tbl(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_phase_tbl(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic [31:0] atan_phase_tbl(input int i);
        logic [31:0] t[30] = '{
            32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
            32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
        return t[i];
    endfunction

    function automatic logic signed [127:0] rotate_round(input longint p, q, a, b);
        logic signed [127:0] acc;
        acc = 128'(p) * 128'(a) + 128'(q) * 128'(b) + (128'sd1 <<< 29);
        return acc >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp_pos(input logic signed [127:0] v,
                                                     inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    task automatic predict_pose(input t_cmd w, output t_pose_out r);
        longint s, c;
        logic signed [127:0] rx, ry;
        heading_sin_cos(w.bh, s, c);
        r.sat = 1'b0;
        if (w.func == ppci_pkg::FUNC_INVERT) begin
            rx = rotate_round(w.bx, w.by, -c, -s);
            ry = rotate_round(w.bx, w.by, s, -c);
            r.heading = -w.bh;
        end else begin
            rx = rotate_round(w.ox, w.oy, c, -s) + 128'(w.bx);
            ry = rotate_round(w.ox, w.oy, s, c) + 128'(w.by);
            r.heading = w.bh + w.oh;
        end
        r.x = clamp_pos(rx, r.sat);
        r.y = clamp_pos(ry, r.sat);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_cmd w;
        t_pose_out e;
        logic next_start;
        if (i_rst_n) begin
            if (start && !busy) begin
                w.func = ppci_pkg::t_func'(i_func);
                w.bx = i_base_x; w.by = i_base_y; w.bh = i_base_heading;
                w.ox = i_other_x; w.oy = i_other_y; w.oh = i_other_heading;
                predict_pose(w, e);
                expected_poses.push_back(e);
                void'(pending_words.pop_front());
            end
            next_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > calm_tail && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
            end else if (pending_words.size() > 0) begin
                w = pending_words[0];
                next_start = 1'b1;
                i_func <= w.func;
                i_base_x <= w.bx; i_base_y <= w.by; i_base_heading <= w.bh;
                i_other_x <= w.ox; i_other_y <= w.oy; i_other_heading <= w.oh;
            end
            start <= next_start;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pose_out e;
        if (i_rst_n && o_done) begin
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h h=%h sat=%b", $time,
                         o_out_x, o_out_y, o_out_heading, o_saturated);
                errors++;
            end else begin
                e = expected_poses.pop_front();
                if (o_out_x !== e.x) begin
                    $display("%0t: out_x expected %h actual %h", $time, e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $display("%0t: out_y expected %h actual %h", $time, e.y, o_out_y);
                    errors++;
                end
                if (o_out_heading !== e.heading) begin
                    $display("%0t: out_heading expected %h actual %h", $time,
                             e.heading, o_out_heading);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_cmd make_word(input ppci_pkg::t_func f,
                                       input logic signed [31:0] bx, by,
                                       input logic signed [15:0] bh,
                                       input logic signed [31:0] ox, oy,
                                       input logic signed [15:0] oh);
        t_cmd w;
        w.func = f; w.bx = bx; w.by = by; w.bh = bh; w.ox = ox; w.oy = oy; w.oh = oh;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
            2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 65535)
                                           : 32'sh80000000 + $urandom_range(0, 65535);
            default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        endcase
    endfunction

    initial begin
        ppci_pkg::t_func fs[2] = '{ppci_pkg::FUNC_COMPOSE, ppci_pkg::FUNC_INVERT};
        logic signed [15:0] hs[6] = '{16'sh0000, 16'sh4000, -16'sh8000, 16'sh7FFF,
                                      -16'sh4000, 16'sh2000};
        foreach (fs[k]) begin
            pending_words.push_back(make_word(fs[k], '0, '0, '0, '0, '0, '0));
            pending_words.push_back(make_word(fs[k], 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF,
                                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF));
            pending_words.push_back(make_word(fs[k], 32'sh80000000, 32'sh80000000, -16'sh8000,
                                              32'sh80000000, 32'sh80000000, -16'sh8000));
            pending_words.push_back(make_word(fs[k], 32'sh7FFFFFFF, 32'sh80000000, 16'sh4000,
                                              32'sh80000000, 32'sh7FFFFFFF, -16'sh1));
            foreach (hs[j])
                pending_words.push_back(make_word(fs[k], 32'sh00010000, -32'sh00020000, hs[j],
                                                  32'sh00030000, 32'sh00008000, hs[5 - j]));
        end
        for (int n = 0; n < 650; n++)
            pending_words.push_back(make_word(ppci_pkg::t_func'($urandom_range(0, 1)),
                                              rand_pos(), rand_pos(), 16'($urandom),
                                              rand_pos(), rand_pos(), 16'($urandom)));
        calm_tail = 100;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0 && expected_poses.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_poses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/ppci_pkg.sv
rtl/ppci_cordic_stage.sv
rtl/ppci_sincos.sv
rtl/ppci_rotate.sv
rtl/planar_pose_compose_invert.sv
rtl/ppci_checker.sv
dv/testbench.sv
